@@ hw/rtl/aabb_affine_transform_defines.svh @@
// Assertion macros shared by the box transform RTL.
// Every macro expects signals named clk and rst in the including scope.
`ifndef AABB_AFFINE_TRANSFORM_DEFINES_SVH
`define AABB_AFFINE_TRANSFORM_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define AAT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define AAT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/aat_pkg.sv @@
// Package for the box transform: register indexes, entry format, matrix type.
// No dependencies.
`timescale 1ns / 1ps

package aat_pkg;

  localparam int ENTRY_W     = 16;  // one signed matrix or translation entry
  localparam int COORD_FRAC  = 16;  // fraction bits of coordinates and sizes
  localparam int CFG_W       = 48;  // three entries per register
  localparam int CFG_IDX_W   = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COL0  = 2'd0,
    REG_COL1  = 2'd1,
    REG_COL2  = 2'd2,
    REG_TRANS = 2'd3
  } reg_idx_t;

  localparam logic [CFG_W-1:0] COL0_RESET  = 48'h0000_0000_1000;
  localparam logic [CFG_W-1:0] COL1_RESET  = 48'h0000_1000_0000;
  localparam logic [CFG_W-1:0] COL2_RESET  = 48'h1000_0000_0000;
  localparam logic [CFG_W-1:0] TRANS_RESET = 48'h0000_0000_0000;

  // col[k][r]: entry for input axis k, output row r; trans[r] per output row
  typedef struct packed {
    logic [2:0][2:0][ENTRY_W-1:0] col;
    logic [2:0][ENTRY_W-1:0]      trans;
  } matrix_t;

endpackage

@@ hw/rtl/aat_mult.sv @@
// Input register and product stage of the box transform pipeline.
// Depends on aat_pkg for the matrix type and entry width.
`timescale 1ns / 1ps

module aat_mult
  import aat_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [COORD_WIDTH-1:0]      center [3],
  input  logic        [COORD_WIDTH-2:0]      size   [3],
  input  matrix_t                            mat,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [COORD_WIDTH+ENTRY_W-1:0] cprod [3][3],
  output logic        [COORD_WIDTH+ENTRY_W-2:0] sprod [3][3]
);

  localparam int PW = COORD_WIDTH + ENTRY_W;
  localparam int QW = COORD_WIDTH + ENTRY_W - 1;

  logic                          a_valid;
  logic                          a_ready;
  logic                          b_ready;
  logic signed [COORD_WIDTH-1:0] a_center [3];
  logic        [COORD_WIDTH-2:0] a_size   [3];
  logic signed [PW-1:0]          cprod_next [3][3];
  logic        [QW-1:0]          sprod_next [3][3];
  logic signed [ENTRY_W-1:0]     e;
  logic        [ENTRY_W-1:0]     ae;

  assign a_ready  = !a_valid || b_ready;
  assign b_ready  = !out_valid || out_ready;
  assign in_ready = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
    if (a_ready && in_valid) begin
      a_center <= center;
      a_size   <= size;
    end
  end

  // Nine signed center products and nine magnitude-times-size products.
  always_comb begin
    e  = '0;
    ae = '0;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        e  = $signed(mat.col[k][r]);
        ae = e[ENTRY_W-1] ? (~e + 1'b1) : e;
        cprod_next[r][k] = PW'(a_center[k]) * PW'(e);
        sprod_next[r][k] = QW'(a_size[k]) * QW'(ae);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_ready) begin
      out_valid <= a_valid;
    end
    if (b_ready && a_valid) begin
      cprod <= cprod_next;
      sprod <= sprod_next;
    end
  end

endmodule

@@ hw/rtl/aat_sum.sv @@
// Accumulation stage: adds products, translation and rounding offset per row.
// Depends on aat_pkg for the matrix type and entry format.
`timescale 1ns / 1ps

module aat_sum
  import aat_pkg::*;
#(
  parameter int COORD_WIDTH      = 32,
  parameter int MATRIX_FRAC_BITS = 12
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [COORD_WIDTH+ENTRY_W-1:0] cprod [3][3],
  input  logic        [COORD_WIDTH+ENTRY_W-2:0] sprod [3][3],
  input  matrix_t                               mat,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [COORD_WIDTH+ENTRY_W+1:0] csum [3],
  output logic        [COORD_WIDTH+ENTRY_W:0]   usum [3]
);

  localparam int SUMW = COORD_WIDTH + ENTRY_W + 2;
  localparam int UW   = COORD_WIDTH + ENTRY_W + 1;
  localparam logic signed [SUMW-1:0] CROUND = SUMW'(1) <<< (MATRIX_FRAC_BITS - 1);
  localparam logic        [UW-1:0]   UROUND = UW'(1) << (MATRIX_FRAC_BITS - 1);

  logic signed [SUMW-1:0] csum_next [3];
  logic        [UW-1:0]   usum_next [3];
  logic signed [SUMW-1:0] tsh       [3];

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      tsh[r] = SUMW'($signed(mat.trans[r])) <<< COORD_FRAC;
      csum_next[r] = SUMW'(cprod[r][0]) + SUMW'(cprod[r][1]) + SUMW'(cprod[r][2])
                   + tsh[r] + CROUND;
      usum_next[r] = UW'(sprod[r][0]) + UW'(sprod[r][1]) + UW'(sprod[r][2]) + UROUND;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      csum <= csum_next;
      usum <= usum_next;
    end
  end

endmodule

@@ hw/rtl/aat_sat.sv @@
// Output stage: drops the fraction bits, clamps each field, registers the result.
// Depends on aat_pkg for the entry width.
`timescale 1ns / 1ps

module aat_sat
  import aat_pkg::*;
#(
  parameter int COORD_WIDTH      = 32,
  parameter int MATRIX_FRAC_BITS = 12
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [COORD_WIDTH+ENTRY_W+1:0] csum [3],
  input  logic        [COORD_WIDTH+ENTRY_W:0]   usum [3],
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [COORD_WIDTH-1:0]         out_center [3],
  output logic        [COORD_WIDTH-2:0]         out_size   [3],
  output logic                                  saturated
);

  localparam int SUMW = COORD_WIDTH + ENTRY_W + 2;
  localparam int UW   = COORD_WIDTH + ENTRY_W + 1;
  localparam logic signed [SUMW-1:0] CMAX =
    {{(SUMW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [SUMW-1:0] CMIN =
    {{(SUMW-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};
  localparam logic [UW-1:0] SMAX =
    {{(UW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};

  logic signed [SUMW-1:0]        cshift [3];
  logic        [UW-1:0]          ushift [3];
  logic signed [COORD_WIDTH-1:0] center_next [3];
  logic        [COORD_WIDTH-2:0] size_next   [3];
  logic                          sat_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    sat_next = 1'b0;
    for (int r = 0; r < 3; r++) begin
      cshift[r] = csum[r] >>> MATRIX_FRAC_BITS;
      ushift[r] = usum[r] >> MATRIX_FRAC_BITS;
      if (cshift[r] > CMAX) begin
        center_next[r] = CMAX[COORD_WIDTH-1:0];
        sat_next       = 1'b1;
      end else if (cshift[r] < CMIN) begin
        center_next[r] = CMIN[COORD_WIDTH-1:0];
        sat_next       = 1'b1;
      end else begin
        center_next[r] = cshift[r][COORD_WIDTH-1:0];
      end
      if (ushift[r] > SMAX) begin
        size_next[r] = SMAX[COORD_WIDTH-2:0];
        sat_next     = 1'b1;
      end else begin
        size_next[r] = ushift[r][COORD_WIDTH-2:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_center <= center_next;
      out_size   <= size_next;
      saturated  <= sat_next;
    end
  end

endmodule

@@ hw/rtl/aabb_affine_transform.sv @@
// Top level of the box transform: config registers, stream packing, pipeline.
// Depends on aat_pkg, aat_mult, aat_sum, aat_sat and the assertion macro header.
`timescale 1ns / 1ps
`include "aabb_affine_transform_defines.svh"

// Usage
//   s_* : input boxes, one transfer per box (center x,y,z then size x,y,z).
//   m_* : output boxes, same packing, with the saturation flag on m_tuser.
//   cfg_*: register writes (three matrix columns, translation); cfg_ready is
//          always high. Write only while no box is in flight.
// Throughput: one box per cycle, sustained, when m_tready stays high.
// Pipeline: four register stages (input, products, sums, clamp).
// The product stage (a signed coordinate times a 16-bit entry) and the
//   five-term row sum set the clock period.
// Stall: each stage advances when the stage after it is empty or moving, so
//   m_tready low holds the result on the port and fills the pipeline; once
//   all four stages hold a box, s_tready drops. Nothing is lost or repeated.
// Reset: synchronous; empties the pipeline and loads the identity matrix
//   with zero translation.
module aabb_affine_transform
  import aat_pkg::*;
#(
  parameter int COORD_WIDTH      = 32,
  parameter int MATRIX_FRAC_BITS = 12
) (
  input  logic                                         clk,
  input  logic                                         rst,
  // s_tdata: center_x, center_y, center_z, size_x, size_y, size_z, zero fill
  input  logic                                         s_tvalid,
  output logic                                         s_tready,
  input  logic [((6*COORD_WIDTH-3+7)/8)*8-1:0]         s_tdata,
  // m_tdata: out_center_x/y/z, out_size_x/y/z, zero fill
  output logic                                         m_tvalid,
  input  logic                                         m_tready,
  output logic [((6*COORD_WIDTH-3+7)/8)*8-1:0]         m_tdata,
  // m_tuser: saturated
  output logic [0:0]                                   m_tuser,
  input  logic                                         cfg_valid,
  output logic                                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]                         cfg_index,
  input  logic [CFG_W-1:0]                             cfg_data
);

  localparam int CW = COORD_WIDTH;
  localparam int SW = COORD_WIDTH - 1;
  localparam logic signed [CW-1:0] OUT_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] OUT_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic        [SW-1:0] SIZE_MAX = {SW{1'b1}};

  // Configuration registers
  logic [CFG_W-1:0] col0;
  logic [CFG_W-1:0] col1;
  logic [CFG_W-1:0] col2;
  logic [CFG_W-1:0] translation;
  matrix_t          mat;

  // Unpacked stream payload
  logic signed [CW-1:0] in_center  [3];
  logic        [SW-1:0] in_size    [3];
  logic signed [CW-1:0] out_center [3];
  logic        [SW-1:0] out_size   [3];
  logic                 out_sat;

  // Inter-stage payload
  logic                            mult_valid;
  logic                            mult_ready;
  logic signed [CW+ENTRY_W-1:0]    cprod [3][3];
  logic        [CW+ENTRY_W-2:0]    sprod [3][3];
  logic                            sum_valid;
  logic                            sum_ready;
  logic signed [CW+ENTRY_W+1:0]    csum  [3];
  logic        [CW+ENTRY_W:0]      usum  [3];

  assign cfg_ready = 1'b1;

  // Take every write; all four indexes name a register.
  always_ff @(posedge clk) begin
    if (rst) begin
      col0        <= COL0_RESET;
      col1        <= COL1_RESET;
      col2        <= COL2_RESET;
      translation <= TRANS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_COL0:  col0        <= cfg_data;
        REG_COL1:  col1        <= cfg_data;
        REG_COL2:  col2        <= cfg_data;
        REG_TRANS: translation <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    mat.col[0] = col0;
    mat.col[1] = col1;
    mat.col[2] = col2;
    mat.trans  = translation;
  end

  // Split the input word; centers sit below the sizes.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      in_center[k] = $signed(s_tdata[k*CW +: CW]);
      in_size[k]   = s_tdata[3*CW + k*SW +: SW];
    end
  end

  aat_mult #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_mult (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .center    (in_center),
    .size      (in_size),
    .mat       (mat),
    .out_valid (mult_valid),
    .out_ready (mult_ready),
    .cprod     (cprod),
    .sprod     (sprod)
  );

  aat_sum #(
    .COORD_WIDTH      (COORD_WIDTH),
    .MATRIX_FRAC_BITS (MATRIX_FRAC_BITS)
  ) u_sum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mult_valid),
    .in_ready  (mult_ready),
    .cprod     (cprod),
    .sprod     (sprod),
    .mat       (mat),
    .out_valid (sum_valid),
    .out_ready (sum_ready),
    .csum      (csum),
    .usum      (usum)
  );

  aat_sat #(
    .COORD_WIDTH      (COORD_WIDTH),
    .MATRIX_FRAC_BITS (MATRIX_FRAC_BITS)
  ) u_sat (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (sum_valid),
    .in_ready   (sum_ready),
    .csum       (csum),
    .usum       (usum),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_center (out_center),
    .out_size   (out_size),
    .saturated  (out_sat)
  );

  // Pack the result word with zero fill above the last size.
  always_comb begin
    m_tdata = '0;
    for (int k = 0; k < 3; k++) begin
      m_tdata[k*CW +: CW]        = out_center[k];
      m_tdata[3*CW + k*SW +: SW] = out_size[k];
    end
  end

  assign m_tuser = out_sat;

  `AAT_ASSERT_IMP(a_stall_needs_full, !s_tready, m_tvalid && !m_tready,
                  "input stalled while output free")
  `AAT_ASSERT_IMP(a_sat_at_bound, m_tvalid && m_tuser[0],
                  out_center[0] == OUT_MAX || out_center[0] == OUT_MIN ||
                  out_center[1] == OUT_MAX || out_center[1] == OUT_MIN ||
                  out_center[2] == OUT_MAX || out_center[2] == OUT_MIN ||
                  out_size[0] == SIZE_MAX || out_size[1] == SIZE_MAX ||
                  out_size[2] == SIZE_MAX,
                  "saturation flag without a clamped field")
  `AAT_ASSERT_IMP(a_empty_after_reset, $past(rst), !m_tvalid,
                  "output valid right after reset")
  `AAT_ASSERT_NEXT(a_trans_write, cfg_valid && cfg_ready && cfg_index == REG_TRANS,
                   translation == $past(cfg_data), "translation write lost")

endmodule
